FILE: rtl/huffman_tree_stream_decoder_top_macros.svh
// Assertion macros used by the Huffman tree stream decoder top level.
`ifndef HUFFMAN_TREE_STREAM_DECODER_TOP_MACROS_SVH
`define HUFFMAN_TREE_STREAM_DECODER_TOP_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define HTSD_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define HTSD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/htsd_pkg.sv
// Package with types and constants of the Huffman tree stream decoder.
package htsd_pkg;

  localparam int unsigned MaxInternalNodes = 255;
  localparam int unsigned SymbolBits = 8;
  localparam int unsigned ChildBits = 1 + SymbolBits;
  localparam int unsigned EntryBits = 2 * ChildBits;
  localparam int unsigned HeaderCountBytes = 4;

  typedef logic [1:0] kind_t;
  localparam kind_t KindSymbol = 2'd0;
  localparam kind_t KindEmpty = 2'd1;
  localparam kind_t KindTruncated = 2'd2;
  localparam kind_t KindBadTree = 2'd3;

  typedef enum logic [3:0] {
    PhHeader = 4'b0001,
    PhTree = 4'b0010,
    PhDecode = 4'b0100,
    PhIdle = 4'b1000
  } phase_e;

  typedef enum logic [3:0] {
    StWait = 4'b0001,
    StBit = 4'b0010,
    StFin = 4'b0100,
    StFlush = 4'b1000
  } step_e;

endpackage

FILE: rtl/huffman_tree_stream_decoder_top.sv
// Top level of the Huffman tree stream decoder.
//
// The slave stream carries the compressed file one byte per transfer, with
// tlast marking the final byte of the file. The master stream carries the
// results: tuser holds the result kind, tdata the symbol and the end of text
// flag, and tlast marks the last result that one input byte causes.
// A byte is worked one bit per cycle through the tree walk, which reads one
// node memory entry per cycle from a registered read port. A header byte
// takes a single step, a bitstream byte one step per bit until the byte or its
// text ends. StFin and StFlush then close each byte and StWait waits for the
// next transfer, so a new input byte is taken only once the last is through.
// The first result of a byte passes through the one-entry result buffer
// before it reaches the output register.
// Reset returns all control state to the header phase; the node memory is
// not cleared, since the tree is always loaded before it is walked.
// A stall on the master side holds the output register and a one-entry
// result buffer behind it; the bit walk then waits until space frees up,
// and no input transfer is taken until the byte's results have left the buffer.
// After the final byte of a file the phase and the decoding state restart.
module huffman_tree_stream_decoder_top
  import htsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte[7:0]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // symbol[7:0], end_of_text[8], zero[15:9]
  output logic [1:0]  m_axis_tuser_o,   // kind[1:0]
  output logic        m_axis_tlast_o
);

`include "huffman_tree_stream_decoder_top_macros.svh"

  step_e st_q, st_d;
  phase_e ph_q, ph_d;
  logic [2:0] hcnt_q, hcnt_d;
  logic [31:0] sl_q, sl_d;
  logic [7:0] total_q, total_d;
  logic [7:0] lidx_q, lidx_d;
  logic side_q, side_d;
  logic [SymbolBits-1:0] buf_q, buf_d;
  logic [3:0] bcnt_q, bcnt_d;
  logic [7:0] walk_q, walk_d;
  logic [ChildBits-1:0] lchild_q, lchild_d;
  logic [7:0] byte_q;
  logic fin_q;
  logic [2:0] bidx_q, bidx_d;

  logic [EntryBits-1:0] mem_q [MaxInternalNodes];
  logic [EntryBits-1:0] rd_q;
  logic wr_en;
  logic [EntryBits-1:0] wr_data;

  logic out_v_q, out_v_d, out_last_q, out_last_d, out_eot_q, out_eot_d;
  kind_t out_kind_q, out_kind_d;
  logic [7:0] out_sym_q, out_sym_d;
  logic pend_v_q, pend_v_d, pend_eot_q, pend_eot_d;
  kind_t pend_kind_q, pend_kind_d;
  logic [7:0] pend_sym_q, pend_sym_d;

  logic emit, flush, out_free, stall;
  kind_t e_kind;
  logic [7:0] e_sym;
  logic e_eot;
  logic bit_v;
  logic [ChildBits-1:0] child, dchild;

  assign out_free = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = (st_q == StWait);
  assign bit_v = byte_q[bidx_q];
  assign child = {bit_v, buf_q};
  assign dchild = bit_v ? rd_q[EntryBits-1:ChildBits] : rd_q[ChildBits-1:0];
  assign wr_data = {child, lchild_q};

  always_comb begin
    st_d = st_q;
    ph_d = ph_q;
    hcnt_d = hcnt_q;
    sl_d = sl_q;
    total_d = total_q;
    lidx_d = lidx_q;
    side_d = side_q;
    buf_d = buf_q;
    bcnt_d = bcnt_q;
    walk_d = walk_q;
    lchild_d = lchild_q;
    bidx_d = bidx_q;
    wr_en = 1'b0;
    emit = 1'b0;
    flush = 1'b0;
    e_kind = KindSymbol;
    e_sym = '0;
    e_eot = 1'b0;
    case (st_q)
      StWait: begin
        bidx_d = '0;
        if (s_axis_tvalid_i) begin
          st_d = StBit;
        end
      end
      StBit: begin
        bidx_d = bidx_q + 3'd1;
        if (bidx_q == 3'd7) begin
          st_d = StFin;
        end
        case (ph_q)
          PhHeader: begin
            st_d = StFin;
            if (hcnt_q < 3'(HeaderCountBytes)) begin
              sl_d[{hcnt_q[1:0], 3'b000} +: 8] = byte_q;
              hcnt_d = hcnt_q + 3'd1;
            end else if (byte_q == 8'd0) begin
              emit = 1'b1;
              e_kind = KindBadTree;
              ph_d = PhIdle;
            end else begin
              total_d = byte_q;
              lidx_d = '0;
              side_d = 1'b0;
              buf_d = '0;
              bcnt_d = '0;
              ph_d = PhTree;
            end
          end
          PhTree: begin
            if (bcnt_q != 4'(SymbolBits)) begin
              buf_d[bcnt_q[2:0]] = bit_v;
              bcnt_d = bcnt_q + 4'd1;
            end else begin
              buf_d = '0;
              bcnt_d = '0;
              if ((!child[0] && child[ChildBits-1:1] >= lidx_q) ||
                  (32'(lidx_q) >= MaxInternalNodes)) begin
                emit = 1'b1;
                e_kind = KindBadTree;
                ph_d = PhIdle;
                st_d = StFin;
              end else if (!side_q) begin
                lchild_d = child;
                side_d = 1'b1;
              end else begin
                wr_en = 1'b1;
                side_d = 1'b0;
                lidx_d = lidx_q + 8'd1;
                if (lidx_q + 8'd1 >= total_q) begin
                  walk_d = total_q - 8'd1;
                  if (sl_q == 32'd0) begin
                    emit = 1'b1;
                    e_kind = KindEmpty;
                    ph_d = PhIdle;
                    st_d = StFin;
                  end else begin
                    ph_d = PhDecode;
                  end
                end
              end
            end
          end
          PhDecode: begin
            if (dchild[0]) begin
              sl_d = sl_q - 32'd1;
              emit = 1'b1;
              e_kind = KindSymbol;
              e_sym = dchild[ChildBits-1:1];
              e_eot = (sl_q == 32'd1);
              walk_d = total_q - 8'd1;
              if (sl_q == 32'd1) begin
                ph_d = PhIdle;
                st_d = StFin;
              end
            end else begin
              walk_d = dchild[ChildBits-1:1];
            end
          end
          default: begin
            st_d = StFin;
          end
        endcase
      end
      StFin: begin
        st_d = StFlush;
        if (fin_q) begin
          if (ph_q != PhIdle) begin
            emit = 1'b1;
            e_kind = KindTruncated;
          end
          ph_d = PhHeader;
          hcnt_d = '0;
          sl_d = '0;
          total_d = '0;
          lidx_d = '0;
          side_d = 1'b0;
          buf_d = '0;
          bcnt_d = '0;
          walk_d = '0;
        end
      end
      StFlush: begin
        flush = 1'b1;
        st_d = StWait;
      end
      default: begin
        st_d = StWait;
      end
    endcase

    stall = (emit && pend_v_q && !out_free) || (flush && pend_v_q && !out_free);
    if (stall) begin
      st_d = st_q;
      ph_d = ph_q;
      hcnt_d = hcnt_q;
      sl_d = sl_q;
      total_d = total_q;
      lidx_d = lidx_q;
      side_d = side_q;
      buf_d = buf_q;
      bcnt_d = bcnt_q;
      walk_d = walk_q;
      lchild_d = lchild_q;
      bidx_d = bidx_q;
      wr_en = 1'b0;
    end

    out_v_d = out_v_q && !m_axis_tready_i;
    out_kind_d = out_kind_q;
    out_sym_d = out_sym_q;
    out_eot_d = out_eot_q;
    out_last_d = out_last_q;
    pend_v_d = pend_v_q;
    pend_kind_d = pend_kind_q;
    pend_sym_d = pend_sym_q;
    pend_eot_d = pend_eot_q;
    if (!stall && (emit || flush)) begin
      if (pend_v_q) begin
        out_v_d = 1'b1;
        out_kind_d = pend_kind_q;
        out_sym_d = pend_sym_q;
        out_eot_d = pend_eot_q;
        out_last_d = flush;
        pend_v_d = 1'b0;
      end
      if (emit) begin
        pend_v_d = 1'b1;
        pend_kind_d = e_kind;
        pend_sym_d = e_sym;
        pend_eot_d = e_eot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StWait;
      ph_q <= PhHeader;
      hcnt_q <= '0;
      sl_q <= '0;
      total_q <= '0;
      lidx_q <= '0;
      side_q <= 1'b0;
      buf_q <= '0;
      bcnt_q <= '0;
      walk_q <= '0;
      bidx_q <= '0;
      out_v_q <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
      hcnt_q <= hcnt_d;
      sl_q <= sl_d;
      total_q <= total_d;
      lidx_q <= lidx_d;
      side_q <= side_d;
      buf_q <= buf_d;
      bcnt_q <= bcnt_d;
      walk_q <= walk_d;
      bidx_q <= bidx_d;
      out_v_q <= out_v_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lchild_q <= lchild_d;
    out_kind_q <= out_kind_d;
    out_sym_q <= out_sym_d;
    out_eot_q <= out_eot_d;
    out_last_q <= out_last_d;
    pend_kind_q <= pend_kind_d;
    pend_sym_q <= pend_sym_d;
    pend_eot_q <= pend_eot_d;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      byte_q <= s_axis_tdata_i;
      fin_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[lidx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && (lidx_q == walk_d)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem_q[walk_d];
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o = {7'b0, out_eot_q, out_sym_q};
  assign m_axis_tuser_o = out_kind_q;
  assign m_axis_tlast_o = out_last_q;

  `HTSD_ASSERT_IMPL(a_ready_no_pend, s_axis_tready_o, !pend_v_q,
    "Input ready while a result of the previous byte is still buffered.")
  `HTSD_ASSERT_IMPL(a_walk_in_tree, ph_q == PhDecode, walk_q < total_q,
    "Tree walk points past the loaded nodes.")
  `HTSD_ASSERT_NEXT(a_out_hold, out_v_q && !m_axis_tready_i,
    out_v_q && $stable(out_sym_q) && $stable(out_kind_q),
    "Stalled output result changed.")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the Huffman tree stream decoder top level.
module tb_top;
  import htsd_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] symbol;
    logic       eot;
    logic       last;
  } result_t;

  localparam logic [2:0] PHeader = 3'd0;
  localparam logic [2:0] PTree = 3'd1;
  localparam logic [2:0] PDecode = 3'd2;
  localparam logic [2:0] PIdle = 3'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  huffman_tree_stream_decoder_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state.
  logic [2:0]  ph;
  logic [2:0]  hdr_cnt;
  logic [31:0] sym_left;
  logic [7:0]  node_total;
  logic [7:0]  load_idx;
  logic        load_side;
  logic [15:0] bit_buf;
  logic [4:0]  bit_cnt;
  logic [17:0] nodes [MaxInternalNodes];
  logic [7:0]  walk;

  result_t     expected_q[$];
  int          errors;
  int          results_seen;
  int          bytes_sent;
  int          cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  function automatic void restart_decoder();
    ph = PHeader;
    hdr_cnt = '0;
    sym_left = '0;
    node_total = '0;
    load_idx = '0;
    load_side = 1'b0;
    bit_buf = '0;
    bit_cnt = '0;
    walk = '0;
  endfunction

  function automatic void push_result(kind_t k, logic [7:0] s, logic e);
    result_t r;
    r.kind = k;
    r.symbol = s;
    r.eot = e;
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_byte(logic [7:0] data, logic fin);
    int          start;
    logic [8:0]  child;
    logic [17:0] entry;
    start = expected_q.size();
    if (ph == PHeader) begin
      if (hdr_cnt < HeaderCountBytes) begin
        sym_left = sym_left | (32'(data) << (8 * hdr_cnt));
        hdr_cnt++;
      end else if (data == 0 || data > MaxInternalNodes) begin
        push_result(KindBadTree, 8'd0, 1'b0);
        ph = PIdle;
      end else begin
        node_total = data;
        load_idx = '0;
        load_side = 1'b0;
        bit_buf = '0;
        bit_cnt = '0;
        ph = PTree;
      end
    end else begin
      for (int b = 0; b < 8; b++) begin
        if (ph == PTree) begin
          bit_buf = bit_buf | (16'(data[b]) << bit_cnt);
          bit_cnt++;
          if (bit_cnt < ChildBits) continue;
          child = bit_buf[8:0];
          bit_buf = '0;
          bit_cnt = '0;
          if ((!child[0] && child[8:1] >= load_idx) || load_idx >= MaxInternalNodes) begin
            push_result(KindBadTree, 8'd0, 1'b0);
            ph = PIdle;
            break;
          end
          if (!load_side) begin
            nodes[load_idx] = {9'd0, child};
            load_side = 1'b1;
          end else begin
            nodes[load_idx][17:9] = child;
            load_side = 1'b0;
            load_idx++;
            if (load_idx >= node_total) begin
              walk = node_total - 8'd1;
              if (sym_left == 0) begin
                push_result(KindEmpty, 8'd0, 1'b0);
                ph = PIdle;
                break;
              end
              ph = PDecode;
            end
          end
        end else if (ph == PDecode) begin
          entry = nodes[walk];
          child = data[b] ? entry[17:9] : entry[8:0];
          if (child[0]) begin
            sym_left--;
            push_result(KindSymbol, child[8:1], sym_left == 0);
            walk = node_total - 8'd1;
            if (sym_left == 0) begin
              ph = PIdle;
              break;
            end
          end else begin
            walk = child[8:1];
          end
        end else begin
          break;
        end
      end
    end
    if (fin) begin
      if (ph != PIdle) push_result(KindTruncated, 8'd0, 1'b0);
      restart_decoder();
    end
    if (expected_q.size() > start) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] data, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= data;
    s_axis_tlast_i <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_byte(data, fin);
    bytes_sent++;
  endtask

  // Bit writer that packs a file LSB first.
  logic [7:0] file_q[$];
  logic [7:0] cur_byte;
  int         cur_bits;

  function automatic void put_bits(int unsigned value, int n);
    for (int i = 0; i < n; i++) begin
      cur_byte[cur_bits] = value[i];
      cur_bits++;
      if (cur_bits == 8) begin
        file_q.push_back(cur_byte);
        cur_byte = '0;
        cur_bits = 0;
      end
    end
  endfunction

  function automatic void start_file(int unsigned count, logic [7:0] leaf_byte);
    file_q.delete();
    cur_byte = '0;
    cur_bits = 0;
    put_bits(count, 32);
    put_bits(leaf_byte, 8);
  endfunction

  task automatic send_file(logic fin_at_end);
    if (cur_bits != 0) put_bits($urandom, 8 - cur_bits);
    foreach (file_q[i]) send_byte(file_q[i], fin_at_end && i == file_q.size() - 1);
  endtask

  // Builds a random tree of n internal nodes, well formed unless allow_bad is set;
  // most children are leaves, the rest chain to earlier nodes, so codes vary in length.
  task automatic put_tree(int n, logic allow_bad);
    for (int i = 0; i < n; i++) begin
      for (int s = 0; s < 2; s++) begin
        logic       leaf;
        logic [7:0] idx;
        leaf = (i == 0) || ($urandom_range(2) != 0);
        idx = leaf ? 8'($urandom) : 8'($urandom_range(i - 1));
        if (allow_bad && $urandom_range(9) == 0) begin
          leaf = 1'b0;
          idx = 8'($urandom_range(255, i));
        end
        put_bits({idx, leaf}, 9);
      end
    end
  endtask

  task automatic put_codes(int n, int count);
    put_bits($urandom, 32);
    for (int i = 0; i < count * 8 / 32 + 1; i++) put_bits($urandom, 32);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // Node count byte of zero is a bad tree; junk after it is ignored until the final byte.
    start_file(3, 8'd0);
    put_bits(8'hFF, 8);
    send_file(1'b1);
    // Empty text on a one-node tree.
    start_file(0, 8'd1);
    put_bits({8'h00, 1'b1}, 9);
    put_bits({8'hFF, 1'b1}, 9);
    send_file(1'b1);
    // Extreme symbols and a full-width count, cut short by the final byte.
    start_file(32'hFFFF_FFFF, 8'd1);
    put_bits({8'h00, 1'b1}, 9);
    put_bits({8'hFF, 1'b1}, 9);
    put_bits(16'h5A5A, 16);
    send_file(1'b1);
    // Child index pointing at itself is a bad tree.
    start_file(5, 8'd2);
    put_bits({8'h01, 1'b1}, 9);
    put_bits({8'h02, 1'b1}, 9);
    put_bits({8'h01, 1'b0}, 9);
    put_bits({8'h00, 1'b0}, 9);
    send_file(1'b1);
    // Eight symbols from eight code bits, then the bits after them are ignored.
    start_file(8, 8'd1);
    put_bits({8'h12, 1'b1}, 9);
    put_bits({8'hED, 1'b1}, 9);
    put_bits(8'hA5, 8);
    put_bits(8'h77, 8);
    send_file(1'b1);
    // Final byte in the middle of the header.
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(int budget);
    int n;
    int count;
    while (bytes_sent < budget) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(32, 1) : $urandom_range(6, 1);
      if ($urandom_range(9) == 0) n = ($urandom_range(1) != 0) ? 0 : 1;
      count = $urandom_range(12);
      if ($urandom_range(19) == 0) count = 0;
      start_file(count, 8'(n));
      if (n == 0) begin
        put_bits($urandom, 16);
      end else begin
        put_tree(n, $urandom_range(7) == 0);
        put_codes(n, count);
      end
      if ($urandom_range(7) == 0) file_q = file_q[0:$urandom_range(file_q.size() - 1)];
      send_file(1'b1);
    end
    wait_drained();
  endtask

  // Result checker and receiver backpressure.
  always @(posedge clk_i) begin
    result_t got;
    result_t exp_r;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind = m_axis_tuser_o;
      got.symbol = m_axis_tdata_o[7:0];
      got.eot = m_axis_tdata_o[8];
      got.last = m_axis_tlast_o;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result kind %0d symbol %0d", got.kind, got.symbol);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.kind != exp_r.kind) begin
          $error("kind expected %0d actual %0d", exp_r.kind, got.kind);
          errors++;
        end
        if (got.symbol != exp_r.symbol) begin
          $error("symbol expected %0d actual %0d", exp_r.symbol, got.symbol);
          errors++;
        end
        if (got.eot != exp_r.eot) begin
          $error("end_of_text expected %0d actual %0d", exp_r.eot, got.eot);
          errors++;
        end
        if (got.last != exp_r.last) begin
          $error("last_in_run expected %0d actual %0d", exp_r.last, got.last);
          errors++;
        end
        if (m_axis_tdata_o[15:9] != 7'd0) begin
          $error("tdata padding expected 0 actual %0h", m_axis_tdata_o[15:9]);
          errors++;
        end
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    errors = 0;
    results_seen = 0;
    bytes_sent = 0;
    cycles = 0;
    send_idle_pct = 23;
    recv_idle_pct = 73;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tlast_i = 1'b0;
    m_axis_tready_i = 1'b0;
    restart_decoder();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(130);
    send_idle_pct = 73;
    recv_idle_pct = 23;
    test_random(220);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(295);
    $display("Sent %0d bytes of compressed files, checked %0d results.", bytes_sent,
             results_seen);
    $display("Covered bad trees, empty texts, truncation and tree sizes up to 32 nodes.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
